// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Check that cons holds in the same cycle as ante, outside reset.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

`endif

// File: rtl/core/twss_pkg.sv
// ----------------------------------------------------------------------------
// twss_pkg
// Types and constants shared by the time window sample screen.
// ----------------------------------------------------------------------------
package twss_pkg;

    localparam int FIELD_TIME_W  = 48;
    localparam int WORD_W        = 32;
    localparam int SLOT_W        = 4;
    localparam int COUNT_W       = 5;
    localparam int KEPT_W        = 32;

    localparam int IN_TDATA_W    = 248;
    localparam int OUT_TDATA_W   = 176;

    // input tdata field offsets
    localparam int IN_SLOT_LSB   = 0;
    localparam int IN_START_LSB  = 4;
    localparam int IN_STOP_LSB   = 52;
    localparam int IN_TS_LSB     = 100;
    localparam int IN_X_LSB      = 148;
    localparam int IN_Y_LSB      = 180;
    localparam int IN_DIR_LSB    = 212;

    // output tdata field offsets
    localparam int OUT_TS_LSB    = 0;
    localparam int OUT_X_LSB     = 48;
    localparam int OUT_Y_LSB     = 80;
    localparam int OUT_DIR_LSB   = 112;
    localparam int OUT_KEPT_LSB  = 144;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

    // one transaction as it travels down the cell chain
    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [SLOT_W-1:0]   window_index;
        logic [WORD_W-1:0]   x_value;
        logic [WORD_W-1:0]   y_value;
        logic [WORD_W-1:0]   direction;
        logic                last_sample;
        logic                hit;
    } item_t;

endpackage

// File: rtl/core/twss_cell.sv
// ----------------------------------------------------------------------------
// twss_cell
// One window slot: holds start/stop, captures loads addressed to it and
// tests passing samples against its window.
// ----------------------------------------------------------------------------
module twss_cell #(
    parameter int CELL_IDX   = 0,
    parameter int TIME_WIDTH = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic [twss_pkg::COUNT_W-1:0]        window_count,
    input  twss_pkg::item_t                     item_in,
    input  logic [TIME_WIDTH-1:0]               time_a_in,
    input  logic [TIME_WIDTH-1:0]               time_b_in,
    output twss_pkg::item_t                     item_out,
    output logic [TIME_WIDTH-1:0]               time_a_out,
    output logic [TIME_WIDTH-1:0]               time_b_out
);

    twss_pkg::item_t         item_reg;
    twss_pkg::item_t         item_next;
    logic [TIME_WIDTH-1:0]   start_reg;
    logic [TIME_WIDTH-1:0]   stop_reg;
    logic [TIME_WIDTH-1:0]   time_a_reg;
    logic [TIME_WIDTH-1:0]   time_b_reg;
    logic                    active;
    logic                    is_load;
    logic                    in_win;

    assign active  = int'(window_count) > CELL_IDX;
    assign is_load = item_in.valid && (item_in.kind == twss_pkg::KIND_LOAD)
                     && (int'(item_in.window_index) == CELL_IDX);
    assign in_win  = item_in.valid && (item_in.kind == twss_pkg::KIND_SAMPLE) && active
                     && (time_a_in >= start_reg) && (time_a_in < stop_reg);

    always_comb
    begin
        item_next     = item_in;
        item_next.hit = item_in.hit | in_win;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg  <= '0;
            start_reg <= '0;
            stop_reg  <= '0;
        end
        else if (adv)
        begin
            item_reg <= item_next;
            if (is_load)
            begin
                start_reg <= time_a_in;
                stop_reg  <= time_b_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            time_a_reg <= time_a_in;
            time_b_reg <= time_b_in;
        end
    end

    assign item_out   = item_reg;
    assign time_a_out = time_a_reg;
    assign time_b_out = time_b_reg;

endmodule

// File: rtl/core/twss_out.sv
// ----------------------------------------------------------------------------
// twss_out
// Result register and saturating kept counter at the tail of the chain.
// ----------------------------------------------------------------------------
module twss_out #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  twss_pkg::item_t                     item_in,
    input  logic [TIME_WIDTH-1:0]               time_in,
    output logic                                adv,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [twss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    output logic [twss_pkg::KEPT_W-1:0]         kept_total
);

    localparam int FTW = twss_pkg::FIELD_TIME_W;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [twss_pkg::KEPT_W-1:0]         kept_total_reg;
    logic [twss_pkg::KEPT_W-1:0]         kept_total_next;
    logic [twss_pkg::OUT_TDATA_W-1:0]    tdata_reg;
    logic                                kept_reg;
    logic                                last_reg;
    logic                                is_result;

    // the whole chain moves when the result register is free or being taken
    assign adv       = !out_valid_reg || m_axis_tready;
    assign is_result = item_in.valid && (item_in.kind == twss_pkg::KIND_SAMPLE);

    always_comb
    begin
        kept_total_next = kept_total_reg;
        out_valid_next  = out_valid_reg;
        if (adv)
        begin
            out_valid_next = is_result;
            if (is_result && item_in.hit && (kept_total_reg != twss_pkg::KEPT_MAX))
            begin
                kept_total_next = kept_total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            kept_total_reg <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            kept_total_reg <= kept_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && is_result)
        begin
            tdata_reg <= {kept_total_next, item_in.direction, item_in.y_value,
                          item_in.x_value, FTW'(time_in)};
            kept_reg  <= item_in.hit;
            last_reg  <= item_in.last_sample;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = kept_reg;
    assign m_axis_tlast  = last_reg;
    assign kept_total    = kept_total_reg;

endmodule

// File: rtl/core/time_window_sample_screen_top.sv
// ----------------------------------------------------------------------------
// Time window sample screen
// Screens timestamped samples against a table of start/stop windows.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries both load and sample transactions; tuser
//   selects the kind (0 load a window, 1 screen a sample), tlast marks the
//   final sample. Master stream m_axis returns one result per sample with
//   the kept flag in tuser and the final marker in tlast; loads return none.
//   cfg_wr_en/cfg_wr_data set the number of windows tested; write it only
//   while the block is idle.
//   Each window slot is one cell of a chain; every transaction walks the
//   chain one cell per cycle when not stalled, and its result is taken
//   from the result register after the last cell. The chain accepts one
//   transaction per cycle while the result register drains.
//   A stall on m_axis freezes the whole chain and drops s_axis_tready; no
//   transaction is lost or reordered.
//   Reset empties every window, clears the kept count and sets the window
//   count to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module time_window_sample_screen_top #(
    parameter int NUM_WINDOWS = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // window_index[3:0], window_start[51:4], window_stop[99:52],
    // timestamp[147:100], x_value[179:148], y_value[211:180],
    // direction[243:212], zero pad
    input  logic [twss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,   // kind
    input  logic                                s_axis_tlast,   // last_sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // out_timestamp[47:0], out_x[79:48], out_y[111:80],
    // out_direction[143:112], kept_count[175:144]
    output logic [twss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tuser,   // kept
    output logic                                m_axis_tlast,   // final_res
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [twss_pkg::COUNT_W-1:0]        cfg_wr_data
);

    localparam int FTW = twss_pkg::FIELD_TIME_W;
    localparam int WW  = twss_pkg::WORD_W;

    logic [twss_pkg::COUNT_W-1:0]   window_count_reg;
    logic                           adv;
    logic [twss_pkg::KEPT_W-1:0]    kept_total;

    twss_pkg::item_t                item_chain   [NUM_WINDOWS+1];
    logic [TIME_WIDTH-1:0]          time_a_chain [NUM_WINDOWS+1];
    logic [TIME_WIDTH-1:0]          time_b_chain [NUM_WINDOWS+1];

    logic [FTW-1:0]                 in_start;
    logic [FTW-1:0]                 in_stop;
    logic [FTW-1:0]                 in_ts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            window_count_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = adv;

    assign in_start = s_axis_tdata[twss_pkg::IN_START_LSB +: FTW];
    assign in_stop  = s_axis_tdata[twss_pkg::IN_STOP_LSB +: FTW];
    assign in_ts    = s_axis_tdata[twss_pkg::IN_TS_LSB +: FTW];

    // head of the chain: a load carries start/stop, a sample carries its time
    always_comb
    begin
        item_chain[0].valid        = s_axis_tvalid;
        item_chain[0].kind         = s_axis_tuser;
        item_chain[0].window_index =
            s_axis_tdata[twss_pkg::IN_SLOT_LSB +: twss_pkg::SLOT_W];
        item_chain[0].x_value      = s_axis_tdata[twss_pkg::IN_X_LSB +: WW];
        item_chain[0].y_value      = s_axis_tdata[twss_pkg::IN_Y_LSB +: WW];
        item_chain[0].direction    = s_axis_tdata[twss_pkg::IN_DIR_LSB +: WW];
        item_chain[0].last_sample  = s_axis_tlast;
        item_chain[0].hit          = 1'b0;
        time_a_chain[0] = (s_axis_tuser == twss_pkg::KIND_LOAD) ?
                          TIME_WIDTH'(in_start) : TIME_WIDTH'(in_ts);
        time_b_chain[0] = TIME_WIDTH'(in_stop);
    end

    for (genvar gi = 0; gi < NUM_WINDOWS; gi++)
    begin : g_cell
        twss_cell #(
            .CELL_IDX   (gi),
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .adv          (adv),
            .window_count (window_count_reg),
            .item_in      (item_chain[gi]),
            .time_a_in    (time_a_chain[gi]),
            .time_b_in    (time_b_chain[gi]),
            .item_out     (item_chain[gi+1]),
            .time_a_out   (time_a_chain[gi+1]),
            .time_b_out   (time_b_chain[gi+1])
        );
    end

    twss_out #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_in       (item_chain[NUM_WINDOWS]),
        .time_in       (time_a_chain[NUM_WINDOWS]),
        .adv           (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .kept_total    (kept_total)
    );

    // a load leaving the chain never produces a result
    `ASSERT_NEXT(a_load_no_result, clk, rst_n,
        adv && item_chain[NUM_WINDOWS].valid
            && (item_chain[NUM_WINDOWS].kind == twss_pkg::KIND_LOAD),
        !m_axis_tvalid)

    // saturated count stays saturated
    `ASSERT_NEXT(a_kept_saturate, clk, rst_n,
        kept_total == twss_pkg::KEPT_MAX,
        kept_total == twss_pkg::KEPT_MAX)

    // a kept sample below saturation bumps the count by exactly one
    `ASSERT_NEXT(a_kept_step, clk, rst_n,
        adv && item_chain[NUM_WINDOWS].valid
            && (item_chain[NUM_WINDOWS].kind == twss_pkg::KIND_SAMPLE)
            && item_chain[NUM_WINDOWS].hit && (kept_total != twss_pkg::KEPT_MAX),
        kept_total == $past(kept_total) + 1'b1)

    // the count seen with a result matches the running total
    `ASSERT_SAME(a_count_match, clk, rst_n,
        m_axis_tvalid,
        m_axis_tdata[twss_pkg::OUT_KEPT_LSB +: twss_pkg::KEPT_W] == kept_total)

endmodule

// File: tb/sv/window_screen_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window screen checker
// Watches the load/sample stream, the result stream and the window count
// writes of the time window sample screen. Keeps its own copy of the window
// table and kept total, predicts one result per accepted sample and compares
// every accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module window_screen_checker #(
    parameter int NUM_WINDOWS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [twss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [twss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tuser,
    input  logic                                m_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic [twss_pkg::COUNT_W-1:0]        cfg_wr_data,
    output int                                  mismatch_count,
    output int                                  outstanding
);
    import twss_pkg::*;

    typedef struct {
        logic                      kept;
        logic [FIELD_TIME_W-1:0]   timestamp;
        logic [WORD_W-1:0]         x_value;
        logic [WORD_W-1:0]         y_value;
        logic [WORD_W-1:0]         direction;
        logic [KEPT_W-1:0]         kept_count;
        logic                      final_flag;
    } screen_result_t;

    screen_result_t              screened_q[$];
    logic [FIELD_TIME_W-1:0]     win_start [NUM_WINDOWS];
    logic [FIELD_TIME_W-1:0]     win_stop  [NUM_WINDOWS];
    logic [KEPT_W-1:0]           kept_running;
    logic [COUNT_W-1:0]          tested_windows;
    int                          errors;

    // A window holds t when start <= t < stop; only the first tested_windows count.
    function automatic logic in_any_window(input logic [FIELD_TIME_W-1:0] t);
        int   limit;
        logic hit;
        limit = (tested_windows > NUM_WINDOWS) ? NUM_WINDOWS : int'(tested_windows);
        hit = 1'b0;
        for (int i = 0; i < limit; i++)
        begin
            if (t >= win_start[i] && t < win_stop[i])
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        screen_result_t          want;
        screen_result_t          made;
        logic [SLOT_W-1:0]       slot;
        logic [FIELD_TIME_W-1:0] t;
        logic                    hit;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                win_start[i] = '0;
                win_stop[i]  = '0;
            end
            kept_running   = '0;
            tested_windows = '0;
            screened_q.delete();
            errors         = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (screened_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual timestamp %0h",
                             $time, m_axis_tdata[OUT_TS_LSB +: FIELD_TIME_W]);
                    errors++;
                end
                else
                begin
                    want = screened_q.pop_front();
                    check_field("kept", 64'(want.kept), 64'(m_axis_tuser));
                    check_field("timestamp", 64'(want.timestamp),
                                64'(m_axis_tdata[OUT_TS_LSB +: FIELD_TIME_W]));
                    check_field("x", 64'(want.x_value),
                                64'(m_axis_tdata[OUT_X_LSB +: WORD_W]));
                    check_field("y", 64'(want.y_value),
                                64'(m_axis_tdata[OUT_Y_LSB +: WORD_W]));
                    check_field("direction", 64'(want.direction),
                                64'(m_axis_tdata[OUT_DIR_LSB +: WORD_W]));
                    check_field("kept_count", 64'(want.kept_count),
                                64'(m_axis_tdata[OUT_KEPT_LSB +: KEPT_W]));
                    check_field("final", 64'(want.final_flag), 64'(m_axis_tlast));
                end
            end

            if (cfg_wr_en)
                tested_windows = cfg_wr_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == KIND_LOAD)
                begin
                    slot = s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
                    // drop loads aimed past the end of the table
                    if (slot < NUM_WINDOWS)
                    begin
                        win_start[slot] = s_axis_tdata[IN_START_LSB +: FIELD_TIME_W];
                        win_stop[slot]  = s_axis_tdata[IN_STOP_LSB +: FIELD_TIME_W];
                    end
                end
                else
                begin
                    t   = s_axis_tdata[IN_TS_LSB +: FIELD_TIME_W];
                    hit = in_any_window(t);
                    if (hit && kept_running != KEPT_MAX)
                        kept_running++;
                    made.kept       = hit;
                    made.timestamp  = t;
                    made.x_value    = s_axis_tdata[IN_X_LSB +: WORD_W];
                    made.y_value    = s_axis_tdata[IN_Y_LSB +: WORD_W];
                    made.direction  = s_axis_tdata[IN_DIR_LSB +: WORD_W];
                    made.kept_count = kept_running;
                    made.final_flag = s_axis_tlast;
                    screened_q.push_back(made);
                end
            end

            mismatch_count <= errors;
            outstanding    <= screened_q.size();
        end
    end

endmodule

// File: tb/sv/time_window_sample_screen_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time window sample screen test
// Drives window loads and timestamped samples into the screen under several
// window count settings, with random gaps on both streams and one long
// result-side stall. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module time_window_sample_screen_top_test;
    import twss_pkg::*;

    localparam int NUM_WINDOWS    = 16;
    localparam int TIME_WIDTH     = 48;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [FIELD_TIME_W-1:0] TIME_MAX = '1;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic [IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                       s_axis_tuser  = KIND_LOAD;
    logic                       s_axis_tlast  = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       m_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]         cfg_wr_data   = '0;

    int                         mismatch_count;
    int                         outstanding;

    bit                         no_idle   = 1'b0;
    bit                         hold_req  = 1'b0;
    bit                         hold_done = 1'b0;
    int                         stall_cycles  = 0;
    int                         load_total    = 0;
    int                         sample_total  = 0;
    int                         kept_seen     = 0;
    int                         setting_total = 0;

    // targets for sample timestamps, so random samples land on window edges
    logic [FIELD_TIME_W-1:0]    aim_start [NUM_WINDOWS];
    logic [FIELD_TIME_W-1:0]    aim_stop  [NUM_WINDOWS];

    time_window_sample_screen_top #(
        .NUM_WINDOWS (NUM_WINDOWS),
        .TIME_WIDTH  (TIME_WIDTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    window_screen_checker #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // End the run when neither stream moves for too long.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tuser)
            kept_seen <= kept_seen + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [FIELD_TIME_W-1:0] rand_time();
        logic [FIELD_TIME_W-1:0] t;
        t[31:0]  = $urandom;
        t[47:32] = 16'($urandom);
        return t;
    endfunction

    // Receiver: ready bursts and gaps, plus one long hold when requested.
    initial
    begin
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            gap = pick_gap();
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic offer(input logic kind, input logic [IN_TDATA_W-1:0] data,
                         input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == KIND_LOAD)
            load_total++;
        else
            sample_total++;
    endtask

    // Fields unused by a load carry random noise.
    task automatic send_load(input logic [SLOT_W-1:0] slot,
                             input logic [FIELD_TIME_W-1:0] start,
                             input logic [FIELD_TIME_W-1:0] stop);
        logic [IN_TDATA_W-1:0] data;
        data = '0;
        data[IN_SLOT_LSB +: SLOT_W]        = slot;
        data[IN_START_LSB +: FIELD_TIME_W] = start;
        data[IN_STOP_LSB +: FIELD_TIME_W]  = stop;
        data[IN_TS_LSB +: FIELD_TIME_W]    = rand_time();
        data[IN_X_LSB +: WORD_W]           = $urandom;
        data[IN_Y_LSB +: WORD_W]           = $urandom;
        data[IN_DIR_LSB +: WORD_W]         = $urandom;
        aim_start[slot] = start;
        aim_stop[slot]  = stop;
        offer(KIND_LOAD, data, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_sample(input logic [FIELD_TIME_W-1:0] ts,
                               input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                               input logic [WORD_W-1:0] dir, input logic last);
        logic [IN_TDATA_W-1:0] data;
        data = '0;
        data[IN_SLOT_LSB +: SLOT_W]        = SLOT_W'($urandom_range(0, 15));
        data[IN_START_LSB +: FIELD_TIME_W] = rand_time();
        data[IN_STOP_LSB +: FIELD_TIME_W]  = rand_time();
        data[IN_TS_LSB +: FIELD_TIME_W]    = ts;
        data[IN_X_LSB +: WORD_W]           = x;
        data[IN_Y_LSB +: WORD_W]           = y;
        data[IN_DIR_LSB +: WORD_W]         = dir;
        offer(KIND_SAMPLE, data, last);
    endtask

    // Wait for the last result, then let any trailing load clear the chain.
    task automatic settle();
        int ready_cycles;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        ready_cycles = 0;
        while (ready_cycles < NUM_WINDOWS + 4)
        begin
            @(posedge clk);
            if (m_axis_tready)
                ready_cycles++;
        end
    endtask

    task automatic set_window_count(input logic [COUNT_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        setting_total++;
    endtask

    task automatic random_item();
        logic [SLOT_W-1:0]       slot;
        logic [FIELD_TIME_W-1:0] lo;
        logic [FIELD_TIME_W-1:0] hi;
        logic [FIELD_TIME_W-1:0] ts;
        slot = SLOT_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 25)
        begin
            lo = rand_time();
            case ($urandom_range(0, 7))
                0: hi = lo;
                1: hi = lo - FIELD_TIME_W'($urandom_range(1, 1000));
                2: hi = rand_time();
                3:
                begin
                    lo = '0;
                    hi = FIELD_TIME_W'($urandom_range(1, 1 << 20));
                end
                4: hi = TIME_MAX;
                default: hi = lo + FIELD_TIME_W'($urandom_range(1, 1 << 24));
            endcase
            send_load(slot, lo, hi);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: ts = aim_start[slot] + FIELD_TIME_W'($urandom_range(0, 2)) - 1'b1;
                3, 4:    ts = aim_stop[slot] - FIELD_TIME_W'($urandom_range(0, 1));
                5, 6:    ts = aim_start[slot] + FIELD_TIME_W'($urandom_range(0, 1 << 16));
                7:       ts = $urandom_range(0, 1) ? TIME_MAX : '0;
                default: ts = rand_time();
            endcase
            send_sample(ts, $urandom, $urandom, $urandom, $urandom_range(0, 15) == 0);
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] phase_count [6];
        for (int i = 0; i < NUM_WINDOWS; i++)
        begin
            aim_start[i] = '0;
            aim_stop[i]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // windows are empty and the count is zero out of reset
        send_sample('0, '0, '0, '0, 1'b0);

        set_window_count(5'd16);
        send_load(4'd0, '0, 48'd1);
        send_load(4'd15, TIME_MAX - 1'b1, TIME_MAX);
        send_load(4'd1, 48'd100, 48'd50);          // reversed
        send_load(4'd2, 48'd7, 48'd7);             // empty
        send_load(4'd3, 48'd1000, 48'd2000);
        send_sample('0, '1, '1, '1, 1'b0);
        send_sample(48'd1, '0, '0, '0, 1'b0);
        send_sample(TIME_MAX - 1'b1, '1, '0, '1, 1'b0);
        send_sample(TIME_MAX, '0, '1, '0, 1'b0);
        send_sample(48'd75, $urandom, $urandom, $urandom, 1'b0);
        send_sample(48'd7, $urandom, $urandom, $urandom, 1'b0);
        send_sample(48'd1000, $urandom, $urandom, $urandom, 1'b0);
        send_sample(48'd1999, $urandom, $urandom, $urandom, 1'b0);
        send_sample(48'd2000, $urandom, $urandom, $urandom, 1'b1);

        // drop the top window, then ask for more windows than the table holds
        set_window_count(5'd15);
        send_sample(TIME_MAX - 1'b1, $urandom, $urandom, $urandom, 1'b0);
        set_window_count(5'd31);
        send_sample(TIME_MAX - 1'b1, $urandom, $urandom, $urandom, 1'b1);

        phase_count[0] = 5'd16;
        phase_count[1] = 5'd1;
        phase_count[2] = 5'd31;
        phase_count[3] = 5'd0;
        phase_count[4] = COUNT_W'($urandom_range(0, 31));
        phase_count[5] = COUNT_W'($urandom_range(0, 31));
        for (int phase = 0; phase < 6; phase++)
        begin
            set_window_count(phase_count[phase]);
            no_idle = (phase == 2 || phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the result side while the sender keeps pushing
                if (phase == 2 && n == 10)
                    hold_req = 1'b1;
                random_item();
            end
        end

        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * NUM_WINDOWS + 4) @(posedge clk);

        $display("Sent %0d window loads and %0d samples under %0d window count settings;",
                 load_total, sample_total, setting_total);
        $display("%0d samples came back kept, result stream held off for %0d cycles once.",
                 kept_seen, HOLD_CYCLES);
        if (mismatch_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/twss_pkg.sv
rtl/core/twss_cell.sv
rtl/core/twss_out.sv
rtl/core/time_window_sample_screen_top.sv
tb/sv/window_screen_checker.sv
tb/sv/time_window_sample_screen_top_test.sv
